/* src/hrpl_pkg.sv */
// shared types, codes and hash helper for the hash range partition lookup block
package hrpl_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int TAG_BITS_DEF = 16;

  localparam int HASH_W      = 64;
  localparam int OWNER_W     = 16;
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 144;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TUSER_W = 3;

  localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hCBF29CE484222325;
  localparam logic [HASH_W-1:0] FNV_PRIME_LO = 64'h00000000000001B3;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_KEY    = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FOUND   = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_STORED  = 3'd2,
    ST_CLAMPED = 3'd3,
    ST_ZERO    = 3'd4,
    ST_NOROOM  = 3'd5,
    ST_CLEARED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    SS_IDLE,
    SS_READ,
    SS_CMP,
    SS_HOLD
  } srch_state_t;

  // prime is 2^40 + 0x1b3, so the product is a shift plus a narrow multiply
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    logic [HASH_W-1:0] lo_prod;
    x       = h ^ {56'd0, b};
    lo_prod = x * FNV_PRIME_LO;
    return {x[23:0], 40'd0} + lo_prod;
  endfunction

endpackage

/* src/hrpl_search.sv */
// partition table memory and binary search sequencer with one shared comparator
module hrpl_search #(
  parameter int ENTRIES  = hrpl_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = hrpl_pkg::TAG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [63:0]                  start_hash,
  input  logic [$clog2(ENTRIES+1)-1:0] count,
  input  logic                         wr_en,
  input  logic [$clog2(ENTRIES)-1:0]   wr_idx,
  input  logic [63:0]                  wr_bound,
  input  logic [TAG_BITS-1:0]          wr_tag,
  input  logic                         res_ack,
  output logic                         busy,
  output logic                         res_valid,
  output logic [63:0]                  res_hash,
  output logic [63:0]                  res_bound,
  output logic [TAG_BITS-1:0]          res_tag
);
  import hrpl_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [63:0]         bound_mem [ENTRIES];
  logic [TAG_BITS-1:0] tag_mem   [ENTRIES];

  srch_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [IDX_W-1:0]    hi_r, hi_nxt;
  logic [IDX_W-1:0]    mid_r, mid_nxt;
  logic [63:0]         key_r, key_nxt;
  logic [63:0]         best_bound_r, best_bound_nxt;
  logic [TAG_BITS-1:0] best_tag_r, best_tag_nxt;
  logic [63:0]         rd_bound_r;
  logic [TAG_BITS-1:0] rd_tag_r;

  logic [CNT_W-1:0] mid_sum;
  logic [IDX_W-1:0] mid_idx;
  logic             hit;
  logic [CNT_W-1:0] lo_up;
  logic [IDX_W-1:0] mid_dn;
  logic             step_done;

  assign mid_sum = lo_r + ((CNT_W'(hi_r) - lo_r) >> 1);
  assign mid_idx = mid_sum[IDX_W-1:0];

  // shared comparator and loop bounds
  assign hit    = rd_bound_r <= key_r;
  assign lo_up  = CNT_W'(mid_r) + CNT_W'(1);
  assign mid_dn = mid_r - IDX_W'(1);

  always_comb begin
    if (hit) begin
      step_done = lo_up > CNT_W'(hi_r);
    end else if (mid_r == '0) begin
      step_done = 1'b1;
    end else begin
      step_done = lo_r > CNT_W'(mid_dn);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SS_IDLE: begin
        if (start) state_nxt = SS_READ;
      end
      SS_READ: state_nxt = SS_CMP;
      SS_CMP: begin
        state_nxt = step_done ? SS_HOLD : SS_READ;
      end
      SS_HOLD: begin
        if (res_ack) state_nxt = SS_IDLE;
      end
      default: state_nxt = SS_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    best_bound_nxt = best_bound_r;
    best_tag_nxt   = best_tag_r;
    case (state_r)
      SS_IDLE: begin
        if (start) begin
          lo_nxt  = '0;
          hi_nxt  = IDX_W'(count - CNT_W'(1));
          key_nxt = start_hash;
        end
      end
      SS_READ: mid_nxt = mid_idx;
      SS_CMP: begin
        if (hit) begin
          lo_nxt         = lo_up;
          best_bound_nxt = rd_bound_r;
          best_tag_nxt   = rd_tag_r;
        end else if (mid_r != '0) begin
          hi_nxt = mid_dn;
        end
      end
      SS_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    key_r        <= key_nxt;
    best_bound_r <= best_bound_nxt;
    best_tag_r   <= best_tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bound_mem[wr_idx] <= wr_bound;
      tag_mem[wr_idx]   <= wr_tag;
    end
    rd_bound_r <= bound_mem[mid_idx];
    rd_tag_r   <= tag_mem[mid_idx];
  end

  assign busy      = state_r != SS_IDLE;
  assign res_valid = state_r == SS_HOLD;
  assign res_hash  = key_r;
  assign res_bound = best_bound_r;
  assign res_tag   = best_tag_r;

endmodule

/* src/hash_range_partition_lookup_core.sv */
// top level: fnv-1a hashing, partition table append and lookup, output register
// clear, append and an empty-table lookup or last key byte write their result
// into the output register, so it shows the cycle after the transfer
// a lookup on n entries runs the binary search as a read state and a compare
// state per search step, set by the single registered read port of the table memory
// intake stalls while a search runs or a result waits that is not being taken
// synchronous active-low reset clears counters, hash and valid; tables keep contents
module hash_range_partition_lookup_core #(
  parameter int ENTRIES  = hrpl_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = hrpl_pkg::TAG_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // interval_size, claimant_tag, key_byte, lookup_hash
  input  logic [hrpl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation
  input  logic [hrpl_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // owner_tag, hash_value, entry_bound
  output logic [hrpl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status
  output logic [hrpl_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import hrpl_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [63:0]  in_size;
  logic [15:0]  in_tag;
  logic [7:0]   in_byte;
  logic [63:0]  in_hash;
  op_t          op;

  assign in_size = in_tdata[63:0];
  assign in_tag  = in_tdata[79:64];
  assign in_byte = in_tdata[87:80];
  assign in_hash = in_tdata[151:88];
  assign op      = op_t'(in_tuser);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [63:0]         next_bound_r, next_bound_nxt;
  logic [63:0]         space_r, space_nxt;
  logic [63:0]         run_hash_r, run_hash_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [OWNER_W-1:0]  owner_r, owner_nxt;
  logic [63:0]         hash_r, hash_nxt;
  logic [63:0]         bound_r, bound_nxt;

  logic                srch_start, srch_busy, srch_valid, srch_ack;
  logic [63:0]         srch_key, srch_hash, srch_bound;
  logic [TAG_BITS-1:0] srch_tag;
  logic                wr_en;

  logic                accept, out_free;
  logic [TAG_BITS-1:0] tag_m;
  logic [63:0]         stepped;
  logic                noroom, clamp;
  logic [63:0]         eff_size, new_bound;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !srch_busy && out_free;
  assign accept    = in_tvalid && in_tready;

  assign tag_m     = TAG_BITS'(in_tag);
  assign stepped   = fnv_step(run_hash_r, in_byte);
  assign noroom    = (space_r == '0) || (count_r == CNT_W'(ENTRIES));
  assign clamp     = in_size > space_r;
  assign eff_size  = clamp ? space_r : in_size;
  assign new_bound = next_bound_r + eff_size;

  always_comb begin
    count_nxt      = count_r;
    next_bound_nxt = next_bound_r;
    space_nxt      = space_r;
    run_hash_nxt   = run_hash_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    status_nxt     = status_r;
    owner_nxt      = owner_r;
    hash_nxt       = hash_r;
    bound_nxt      = bound_r;
    srch_start     = 1'b0;
    srch_key       = in_hash;
    srch_ack       = 1'b0;
    wr_en          = 1'b0;

    if (srch_valid && out_free) begin
      srch_ack      = 1'b1;
      out_valid_nxt = 1'b1;
      status_nxt    = ST_FOUND;
      owner_nxt     = OWNER_W'(srch_tag);
      hash_nxt      = srch_hash;
      bound_nxt     = srch_bound;
    end

    if (accept) begin
      case (op)
        OP_CLEAR: begin
          count_nxt      = '0;
          next_bound_nxt = '0;
          space_nxt      = '1;
          out_valid_nxt  = 1'b1;
          status_nxt     = ST_CLEARED;
          owner_nxt      = '0;
          hash_nxt       = '0;
          bound_nxt      = '0;
        end
        OP_APPEND: begin
          out_valid_nxt = 1'b1;
          owner_nxt     = OWNER_W'(tag_m);
          hash_nxt      = '0;
          bound_nxt     = '0;
          if (noroom) begin
            status_nxt = ST_NOROOM;
          end else if (in_size == '0) begin
            status_nxt = ST_ZERO;
          end else begin
            wr_en          = 1'b1;
            status_nxt     = clamp ? ST_CLAMPED : ST_STORED;
            bound_nxt      = next_bound_r;
            count_nxt      = count_r + CNT_W'(1);
            next_bound_nxt = new_bound;
            // bound plus space left always sums to all ones
            space_nxt      = ~new_bound;
          end
        end
        OP_KEY, OP_LOOKUP: begin
          if (op == OP_KEY) begin
            srch_key     = stepped;
            run_hash_nxt = in_tlast ? FNV_BASIS : stepped;
          end
          if (op == OP_LOOKUP || in_tlast) begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_EMPTY;
              owner_nxt     = '0;
              hash_nxt      = srch_key;
              bound_nxt     = '0;
            end else begin
              srch_start = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      next_bound_r <= '0;
      space_r      <= '1;
      run_hash_r   <= FNV_BASIS;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      next_bound_r <= next_bound_nxt;
      space_r      <= space_nxt;
      run_hash_r   <= run_hash_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    owner_r  <= owner_nxt;
    hash_r   <= hash_nxt;
    bound_r  <= bound_nxt;
  end

  hrpl_search #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (srch_start),
    .start_hash (srch_key),
    .count      (count_r),
    .wr_en      (wr_en),
    .wr_idx     (count_r[IDX_W-1:0]),
    .wr_bound   (next_bound_r),
    .wr_tag     (tag_m),
    .res_ack    (srch_ack),
    .busy       (srch_busy),
    .res_valid  (srch_valid),
    .res_hash   (srch_hash),
    .res_bound  (srch_bound),
    .res_tag    (srch_tag)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {bound_r, hash_r, owner_r};
  assign out_tuser  = status_r;

endmodule

/* src/hrpl_checker.sv */
// port-level assertions for the lookup core and the bind that attaches them
module hrpl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [hrpl_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hrpl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [hrpl_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import hrpl_pkg::*;

  // a clear transfer is answered by a valid cleared result in the output register
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_CLEAR |=> out_tvalid && out_tuser == ST_CLEARED)
    else $error("clear transfer not answered next cycle");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_CLEARED |-> out_tdata == '0)
    else $error("cleared result carries nonzero payload");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[15:0] == '0 && out_tdata[143:80] == '0)
    else $error("empty-table result carries owner or bound");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind hash_range_partition_lookup_core hrpl_checker u_hrpl_checker (.*);
